// ===== rtl/cfus_pkg.sv =====
// ----------------------------------------------------------------------------
// cfus_pkg
// types, codes and helper functions of the can firmware upload sequencer
// ----------------------------------------------------------------------------
package cfus_pkg;

    localparam int CHUNK_BYTES = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [7:0] CRC_POLY  = 8'h31;
    localparam logic [7:0] CRC_INIT  = 8'hFF;
    localparam logic [7:0] BOOT_CMD  = 8'hEE;
    localparam logic [10:0] DATA_OFS = 11'd10;
    localparam logic [10:0] RST_OFS  = 11'd20;

    typedef enum logic [2:0] {
        ACT_BOOT  = 3'd0,
        ACT_START = 3'd1,
        ACT_FRAME = 3'd2,
        ACT_TICK  = 3'd3,
        ACT_CHUNK = 3'd4
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_ID      = 3'd0,
        CFG_BOOT_KEY     = 3'd1,
        CFG_FW_SIZE      = 3'd2,
        CFG_TIMEOUT      = 3'd3,
        CFG_MODE_TIMEOUT = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        STAT_IDLE      = 4'd0,
        STAT_WAITING   = 4'd1,
        STAT_NEED      = 4'd2,
        STAT_COMPLETE  = 4'd3,
        STAT_KEY_ERR   = 4'd4,
        STAT_TIMEOUT   = 4'd5,
        STAT_SIZE_ERR  = 4'd6,
        STAT_CRC_FAIL  = 4'd7,
        STAT_FINAL_ERR = 4'd8,
        STAT_BOOT_MODE = 4'd9,
        STAT_BOOT_FAIL = 4'd10
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_KEY   = 3'd1,
        PH_SIZE  = 3'd2,
        PH_NEED  = 3'd3,
        PH_ACK   = 3'd4,
        PH_FINAL = 3'd5,
        PH_MODE  = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        SQ_IDLE = 2'd0,
        SQ_CRC  = 2'd1,
        SQ_EMIT = 2'd2
    } seq_t;

    typedef struct packed {
        logic        tx_valid;
        logic [10:0] tx_id;
        logic [3:0]  tx_len;
        logic [63:0] tx_data;
        logic [3:0]  status;
        logic [31:0] bytes_sent;
        logic        last;
    } res_t;

    // keeps the low n bytes, n of eight or more keeps all
    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (n > 4'(i)) begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    // crc-8 msb first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // frame fields read as zero when nothing is sent
    function automatic res_t make_res(input logic tx, input logic [10:0] id,
                                      input logic [3:0] len, input logic [63:0] data,
                                      input status_t st, input logic [31:0] bytes,
                                      input logic lst);
        res_t r;
        r.tx_valid   = tx;
        r.tx_id      = tx ? id : '0;
        r.tx_len     = tx ? len : '0;
        r.tx_data    = tx ? data : '0;
        r.status     = st;
        r.bytes_sent = bytes;
        r.last       = lst;
        return r;
    endfunction

endpackage

// ===== rtl/cfus_in_if.sv =====
// ----------------------------------------------------------------------------
// cfus_in_if
// input channel: action items with received frames, ticks and chunks
// ----------------------------------------------------------------------------
interface cfus_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [10:0] frame_id;
    logic [3:0]  length;
    logic [63:0] payload;

    modport source (output valid, action, frame_id, length, payload, input ready);
    modport sink (input valid, action, frame_id, length, payload, output ready);
endinterface

// ===== rtl/cfus_out_if.sv =====
// ----------------------------------------------------------------------------
// cfus_out_if
// output channel: frames to send with status and progress
// ----------------------------------------------------------------------------
interface cfus_out_if;
    logic        valid;
    logic        ready;
    logic        tx_valid;
    logic [10:0] tx_id;
    logic [3:0]  tx_len;
    logic [63:0] tx_data;
    logic [3:0]  status;
    logic [31:0] bytes_sent;
    logic        last;

    modport source (output valid, tx_valid, tx_id, tx_len, tx_data, status, bytes_sent,
                    last, input ready);
    modport sink (input valid, tx_valid, tx_id, tx_len, tx_data, status, bytes_sent,
                  last, output ready);
endinterface

// ===== rtl/can_firmware_upload_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// can_firmware_upload_sequencer_core
// host-side sequencer for a can bootloader upload: key, size, chunks with
// crc-8 acks, final reply, plus an enter-boot command
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      beat contents
//  -------  ---  -------------  ----------------------------------------------
//  item     in   valid/ready    action, frame_id, length, payload
//  result   out  valid/ready    tx_valid, tx_id, tx_len, tx_data, status,
//                               bytes_sent, last
//  cfg      in   cfg_we only    cfg_index, cfg_data (no read-back)
//
//  an item is taken when valid and ready are both high; an item that causes no
//  beat leaves ready high; a beat sits in the output register until taken, for
//  items other than a chunk from the next cycle; start gives two beats in a row,
//  everything else at most one; a chunk runs the crc unit one byte per cycle
//  over its bytes, and its beat shows once the crc is done
//  item.ready is low while a beat waits or the crc runs; a stalled result holds
//  rst_n resets phase, counters, crc and config registers at once; no sweep
//
module can_firmware_upload_sequencer_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    cfus_in_if.sink                              item,
    cfus_out_if.source                           result,
    input  logic                                 cfg_we,
    input  logic [cfus_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cfus_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // configuration registers
    logic [10:0] base_id_reg;
    logic [31:0] boot_key_reg;
    logic [31:0] fw_size_reg;
    logic [15:0] timeout_reg;
    logic [15:0] mode_timeout_reg;

    // sequencer and protocol state
    cfus_pkg::seq_t   state_reg, state_next;
    cfus_pkg::phase_t phase_reg, phase_next;
    logic [15:0] tick_reg, tick_next;
    logic [7:0]  exp_crc_reg, exp_crc_next;
    logic [3:0]  chunk_reg, chunk_next;
    logic [31:0] acked_reg, acked_next;
    logic        second_reg, second_next;

    // crc unit: running crc, byte shifter and byte count
    logic [7:0]  crc_reg, crc_next;
    logic [63:0] shift_reg, shift_next;
    logic [3:0]  cnt_reg, cnt_next;

    // output register
    cfus_pkg::res_t res_reg, res_next;

    // derived ids, 11-bit wrap
    logic [10:0] id_main;
    logic [10:0] id_data;
    logic [10:0] id_reset;

    // received frame view: bytes past length read as zero
    logic [63:0] rx;
    logic [7:0]  b0;
    logic [3:0]  chunk_len;
    logic [63:0] chunk_data;

    assign id_main  = base_id_reg;
    assign id_data  = base_id_reg + cfus_pkg::DATA_OFS;
    assign id_reset = base_id_reg + cfus_pkg::RST_OFS;

    assign rx = item.payload & cfus_pkg::byte_mask(item.length);
    assign b0 = rx[7:0];

    // chunk length clamped to the chunk size
    assign chunk_len  = (item.length > 4'(cfus_pkg::CHUNK_BYTES)) ?
                        4'(cfus_pkg::CHUNK_BYTES) : item.length;
    assign chunk_data = item.payload & cfus_pkg::byte_mask(chunk_len);

    assign item.ready   = (state_reg == cfus_pkg::SQ_IDLE);
    assign result.valid = (state_reg == cfus_pkg::SQ_EMIT);

    assign result.tx_valid   = res_reg.tx_valid;
    assign result.tx_id      = res_reg.tx_id;
    assign result.tx_len     = res_reg.tx_len;
    assign result.tx_data    = res_reg.tx_data;
    assign result.status     = res_reg.status;
    assign result.bytes_sent = res_reg.bytes_sent;
    assign result.last       = res_reg.last;

    // configuration writes, indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_id_reg      <= '0;
            boot_key_reg     <= '0;
            fw_size_reg      <= '0;
            timeout_reg      <= 16'd1000;
            mode_timeout_reg <= 16'd100;
        end
        else if (cfg_we)
        begin
            case (cfus_pkg::cfg_idx_t'(cfg_index))
                cfus_pkg::CFG_BASE_ID:      base_id_reg      <= cfg_data[10:0];
                cfus_pkg::CFG_BOOT_KEY:     boot_key_reg     <= cfg_data[31:0];
                cfus_pkg::CFG_FW_SIZE:      fw_size_reg      <= cfg_data[31:0];
                cfus_pkg::CFG_TIMEOUT:      timeout_reg      <= cfg_data[15:0];
                cfus_pkg::CFG_MODE_TIMEOUT: mode_timeout_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cfus_pkg::SQ_IDLE;
            phase_reg   <= cfus_pkg::PH_IDLE;
            tick_reg    <= '0;
            exp_crc_reg <= '0;
            chunk_reg   <= '0;
            acked_reg   <= '0;
            second_reg  <= 1'b0;
            crc_reg     <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            exp_crc_reg <= exp_crc_next;
            chunk_reg   <= chunk_next;
            acked_reg   <= acked_next;
            second_reg  <= second_next;
            crc_reg     <= crc_next;
            cnt_reg     <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        logic [15:0] tick_inc;
        logic [15:0] lim;
        logic        fin;
        logic        fin_tx;
        cfus_pkg::status_t fin_st;

        state_next   = state_reg;
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        exp_crc_next = exp_crc_reg;
        chunk_next   = chunk_reg;
        acked_next   = acked_reg;
        second_next  = second_reg;
        crc_next     = crc_reg;
        shift_next   = shift_reg;
        cnt_next     = cnt_reg;
        res_next     = res_reg;

        // end of run: back to idle, one beat, reset frame if asked
        fin    = 1'b0;
        fin_tx = 1'b0;
        fin_st = cfus_pkg::STAT_IDLE;

        tick_inc = (tick_reg == 16'hFFFF) ? tick_reg : tick_reg + 16'd1;
        lim      = (phase_reg == cfus_pkg::PH_MODE) ? mode_timeout_reg : timeout_reg;

        case (state_reg)
            cfus_pkg::SQ_IDLE:
            begin
                if (item.valid)
                begin
                    case (cfus_pkg::action_t'(item.action))
                        cfus_pkg::ACT_BOOT:
                        begin
                            phase_next = cfus_pkg::PH_MODE;
                            tick_next  = '0;
                            res_next   = cfus_pkg::make_res(1'b1, id_main, 4'd1,
                                             {56'd0, cfus_pkg::BOOT_CMD},
                                             cfus_pkg::STAT_WAITING, acked_reg, 1'b1);
                            state_next = cfus_pkg::SQ_EMIT;
                        end
                        cfus_pkg::ACT_START:
                        begin
                            // reset frame now, key frame as second beat
                            acked_next  = '0;
                            phase_next  = cfus_pkg::PH_KEY;
                            tick_next   = '0;
                            second_next = 1'b1;
                            res_next    = cfus_pkg::make_res(1'b1, id_reset, 4'd1, 64'd0,
                                              cfus_pkg::STAT_WAITING, 32'd0, 1'b0);
                            state_next  = cfus_pkg::SQ_EMIT;
                        end
                        cfus_pkg::ACT_FRAME:
                        begin
                            if (item.frame_id == id_main &&
                                phase_reg inside {cfus_pkg::PH_KEY, cfus_pkg::PH_SIZE,
                                                  cfus_pkg::PH_MODE})
                            begin
                                if (phase_reg == cfus_pkg::PH_KEY)
                                begin
                                    if (b0 == 8'd0)
                                    begin
                                        fin    = 1'b1;
                                        fin_st = cfus_pkg::STAT_KEY_ERR;
                                    end
                                    else
                                    begin
                                        phase_next = cfus_pkg::PH_SIZE;
                                        tick_next  = '0;
                                        res_next   = cfus_pkg::make_res(1'b1, id_main, 4'd4,
                                                         {32'd0, fw_size_reg},
                                                         cfus_pkg::STAT_WAITING,
                                                         acked_reg, 1'b1);
                                        state_next = cfus_pkg::SQ_EMIT;
                                    end
                                end
                                else if (phase_reg == cfus_pkg::PH_SIZE)
                                begin
                                    if (rx[31:0] == fw_size_reg)
                                    begin
                                        phase_next = cfus_pkg::PH_NEED;
                                        tick_next  = '0;
                                        res_next   = cfus_pkg::make_res(1'b0, '0, '0, '0,
                                                         cfus_pkg::STAT_NEED,
                                                         acked_reg, 1'b1);
                                        state_next = cfus_pkg::SQ_EMIT;
                                    end
                                    else
                                    begin
                                        fin    = 1'b1;
                                        fin_tx = 1'b1;
                                        fin_st = cfus_pkg::STAT_SIZE_ERR;
                                    end
                                end
                                else
                                begin
                                    fin    = 1'b1;
                                    fin_st = (b0 != 8'd0) ? cfus_pkg::STAT_BOOT_MODE :
                                                            cfus_pkg::STAT_BOOT_FAIL;
                                end
                            end
                            else if (item.frame_id == id_data &&
                                     phase_reg inside {cfus_pkg::PH_ACK, cfus_pkg::PH_FINAL})
                            begin
                                if (phase_reg == cfus_pkg::PH_ACK)
                                begin
                                    if (b0 == exp_crc_reg)
                                    begin
                                        acked_next = acked_reg + 32'(chunk_reg);
                                        tick_next  = '0;
                                        // a full chunk asks for more, a short one ends
                                        if (chunk_reg == 4'(cfus_pkg::CHUNK_BYTES))
                                        begin
                                            phase_next = cfus_pkg::PH_NEED;
                                            res_next   = cfus_pkg::make_res(1'b0, '0, '0,
                                                             '0, cfus_pkg::STAT_NEED,
                                                             acked_next, 1'b1);
                                        end
                                        else
                                        begin
                                            phase_next = cfus_pkg::PH_FINAL;
                                            res_next   = cfus_pkg::make_res(1'b0, '0, '0,
                                                             '0, cfus_pkg::STAT_WAITING,
                                                             acked_next, 1'b1);
                                        end
                                        state_next = cfus_pkg::SQ_EMIT;
                                    end
                                    else
                                    begin
                                        fin    = 1'b1;
                                        fin_tx = 1'b1;
                                        fin_st = cfus_pkg::STAT_CRC_FAIL;
                                    end
                                end
                                else
                                begin
                                    fin    = 1'b1;
                                    fin_tx = (b0 == 8'd0);
                                    fin_st = (b0 != 8'd0) ? cfus_pkg::STAT_COMPLETE :
                                                            cfus_pkg::STAT_FINAL_ERR;
                                end
                            end
                        end
                        cfus_pkg::ACT_TICK:
                        begin
                            if (phase_reg inside {cfus_pkg::PH_KEY, cfus_pkg::PH_SIZE,
                                                  cfus_pkg::PH_ACK, cfus_pkg::PH_FINAL,
                                                  cfus_pkg::PH_MODE})
                            begin
                                tick_next = tick_inc;
                                // a limit of zero fires on the first tick
                                if (tick_inc >= lim)
                                begin
                                    fin = 1'b1;
                                    if (phase_reg == cfus_pkg::PH_MODE)
                                    begin
                                        fin_st = cfus_pkg::STAT_BOOT_FAIL;
                                    end
                                    else
                                    begin
                                        fin_tx = (phase_reg != cfus_pkg::PH_SIZE);
                                        fin_st = cfus_pkg::STAT_TIMEOUT;
                                    end
                                end
                            end
                        end
                        cfus_pkg::ACT_CHUNK:
                        begin
                            if (phase_reg == cfus_pkg::PH_NEED)
                            begin
                                // frame goes to the output register now, the crc
                                // unit walks the bytes before the beat shows
                                chunk_next = chunk_len;
                                phase_next = cfus_pkg::PH_ACK;
                                tick_next  = '0;
                                crc_next   = cfus_pkg::CRC_INIT;
                                shift_next = chunk_data;
                                cnt_next   = chunk_len;
                                res_next   = cfus_pkg::make_res(1'b1, id_data, chunk_len,
                                                 chunk_data, cfus_pkg::STAT_WAITING,
                                                 acked_reg, 1'b1);
                                state_next = cfus_pkg::SQ_CRC;
                            end
                        end
                        default: ;
                    endcase

                    if (fin)
                    begin
                        phase_next = cfus_pkg::PH_IDLE;
                        tick_next  = '0;
                        res_next   = cfus_pkg::make_res(fin_tx, id_reset, 4'd1, 64'd0,
                                         fin_st, acked_reg, 1'b1);
                        state_next = cfus_pkg::SQ_EMIT;
                    end
                end
            end
            cfus_pkg::SQ_CRC:
            begin
                // one byte per cycle through the crc unit
                if (cnt_reg == 4'd0)
                begin
                    exp_crc_next = crc_reg;
                    state_next   = cfus_pkg::SQ_EMIT;
                end
                else
                begin
                    crc_next   = cfus_pkg::crc8_byte(crc_reg, shift_reg[7:0]);
                    shift_next = shift_reg >> 8;
                    cnt_next   = cnt_reg - 4'd1;
                end
            end
            cfus_pkg::SQ_EMIT:
            begin
                if (result.ready)
                begin
                    if (second_reg)
                    begin
                        // key frame follows the reset frame of a start
                        second_next = 1'b0;
                        res_next    = cfus_pkg::make_res(1'b1, id_main, 4'd4,
                                          {32'd0, boot_key_reg},
                                          cfus_pkg::STAT_WAITING, acked_reg, 1'b1);
                    end
                    else
                    begin
                        state_next = cfus_pkg::SQ_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = cfus_pkg::SQ_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the can firmware upload sequencer: directed and
// random upload, boot-mode and noise traffic against an in-bench predictor,
// with bursty item input and a stalling result receiver
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // drain time after the last expected beat
    localparam int DRAIN_CYCLES         = 40;
    // longest tick run the generator spends on a deliberate timeout
    localparam int EXPIRE_MAX           = 40;
    localparam int SESSIONS_PER_SETTING = 20;
    // item beats taken by the block before the random part stops
    localparam int ITEM_TARGET          = 1200;
    localparam int REPORT_LIMIT         = 100;
    // an action code the block has no use for
    localparam logic [2:0] ACT_SPARE_TOP = 3'd7;

    typedef struct packed {
        logic [2:0]  action;
        logic [10:0] frame_id;
        logic [3:0]  length;
        logic [63:0] payload;
    } upload_item_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [cfus_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [cfus_pkg::CFG_DATA_W-1:0] cfg_data;

    cfus_in_if  in_if ();
    cfus_out_if out_if ();

    can_firmware_upload_sequencer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (in_if),
        .result    (out_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // items waiting for the driver; the head is the one on the bus
    upload_item_t    pending_q[$];
    // beats the predictor has worked out, oldest first
    cfus_pkg::res_t  beats_q[$];

    int err_count  = 0;
    int beat_count = 0;
    int items_sent = 0;

    // register copies used by both the predictor and the generator
    logic [10:0] reg_base         = '0;
    logic [31:0] reg_key          = '0;
    logic [31:0] reg_size         = '0;
    logic [15:0] reg_timeout      = 16'd1000;
    logic [15:0] reg_mode_timeout = 16'd100;

    // sequencer state as the predictor sees it
    cfus_pkg::phase_t pr_phase     = cfus_pkg::PH_IDLE;
    logic [15:0]      pr_ticks     = '0;
    logic [7:0]       pr_crc       = '0;
    logic [3:0]       pr_chunk_len = '0;
    logic [31:0]      pr_acked     = '0;

    // sender burst and gap counters
    int burst_left = 0;
    int gap_left   = 0;

    // receiver stall pattern
    int          stall_cycle = 0;
    int          stall_mode  = 0;
    logic [31:0] stall_mask  = '1;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // keep the low n bytes; a count of eight or more keeps all
    function automatic logic [63:0] low_bytes(logic [63:0] d, logic [3:0] n);
        if (n >= 4'd8)
        begin
            return d;
        end
        return d & ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    // crc-8, poly 0x31, init 0xff, msb first, over the low n bytes
    function automatic logic [7:0] chunk_crc(logic [63:0] d, logic [3:0] n);
        logic [7:0] crc;
        crc = cfus_pkg::CRC_INIT;
        for (int i = 0; i < 8; i++)
        begin
            if (i < n)
            begin
                crc = crc ^ d[8*i +: 8];
                for (int b = 0; b < 8; b++)
                begin
                    crc = crc[7] ? ({crc[6:0], 1'b0} ^ cfus_pkg::CRC_POLY)
                                 : {crc[6:0], 1'b0};
                end
            end
        end
        return crc;
    endfunction

    task automatic report_mismatch(string msg);
        if (err_count < REPORT_LIMIT)
        begin
            $display("mismatch at %0t ns, beat %0d: %s", $time, beat_count, msg);
        end
        err_count++;
    endtask

    task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    // frame fields read as zero on a beat that carries no frame
    task automatic push_beat(bit tx, logic [10:0] id, logic [3:0] len,
                             logic [63:0] data, cfus_pkg::status_t st);
        cfus_pkg::res_t r;
        r.tx_valid   = tx;
        r.tx_id      = tx ? id : '0;
        r.tx_len     = tx ? len : '0;
        r.tx_data    = tx ? data : '0;
        r.status     = st;
        r.bytes_sent = pr_acked;
        r.last       = 1'b0;
        beats_q.push_back(r);
    endtask

    // ends the run, with or without the reset frame
    task automatic close_run(bit send_rst, cfus_pkg::status_t st);
        pr_phase = cfus_pkg::PH_IDLE;
        pr_ticks = '0;
        push_beat(send_rst, reg_base + cfus_pkg::RST_OFS, 4'd1, 64'd0, st);
    endtask

    task automatic predict_upload_step(upload_item_t it);
        logic [10:0] id_main;
        logic [10:0] id_data;
        logic [3:0]  n;
        logic [63:0] rx;
        logic [7:0]  b0;
        logic [15:0] lim;
        int          queued;
        id_main = reg_base;
        id_data = reg_base + cfus_pkg::DATA_OFS;
        // received frames and chunks both clamp their count at eight
        n       = (it.length > 4'd8) ? 4'd8 : it.length;
        rx      = low_bytes(it.payload, n);
        b0      = rx[7:0];
        queued  = beats_q.size();
        items_sent++;
        case (it.action)
            cfus_pkg::ACT_BOOT:
            begin
                pr_phase = cfus_pkg::PH_MODE;
                pr_ticks = '0;
                push_beat(1'b1, id_main, 4'd1, {56'd0, cfus_pkg::BOOT_CMD},
                          cfus_pkg::STAT_WAITING);
            end
            cfus_pkg::ACT_START:
            begin
                // a start abandons whatever run was going on
                pr_acked = '0;
                push_beat(1'b1, reg_base + cfus_pkg::RST_OFS, 4'd1, 64'd0,
                          cfus_pkg::STAT_WAITING);
                push_beat(1'b1, id_main, 4'd4, {32'd0, reg_key}, cfus_pkg::STAT_WAITING);
                pr_phase = cfus_pkg::PH_KEY;
                pr_ticks = '0;
            end
            cfus_pkg::ACT_FRAME:
            begin
                if ((pr_phase == cfus_pkg::PH_KEY || pr_phase == cfus_pkg::PH_SIZE ||
                     pr_phase == cfus_pkg::PH_MODE) && it.frame_id == id_main)
                begin
                    if (pr_phase == cfus_pkg::PH_KEY)
                    begin
                        // refused key: no reset frame
                        if (b0 == 8'd0)
                        begin
                            close_run(1'b0, cfus_pkg::STAT_KEY_ERR);
                        end
                        else
                        begin
                            pr_phase = cfus_pkg::PH_SIZE;
                            pr_ticks = '0;
                            push_beat(1'b1, id_main, 4'd4, {32'd0, reg_size},
                                      cfus_pkg::STAT_WAITING);
                        end
                    end
                    else if (pr_phase == cfus_pkg::PH_SIZE)
                    begin
                        if (rx[31:0] == reg_size)
                        begin
                            pr_phase = cfus_pkg::PH_NEED;
                            pr_ticks = '0;
                            push_beat(1'b0, '0, '0, '0, cfus_pkg::STAT_NEED);
                        end
                        else
                        begin
                            close_run(1'b1, cfus_pkg::STAT_SIZE_ERR);
                        end
                    end
                    else if (b0 != 8'd0)
                    begin
                        close_run(1'b0, cfus_pkg::STAT_BOOT_MODE);
                    end
                    else
                    begin
                        close_run(1'b0, cfus_pkg::STAT_BOOT_FAIL);
                    end
                end
                else if ((pr_phase == cfus_pkg::PH_ACK || pr_phase == cfus_pkg::PH_FINAL)
                         && it.frame_id == id_data)
                begin
                    if (pr_phase == cfus_pkg::PH_ACK)
                    begin
                        if (b0 == pr_crc)
                        begin
                            pr_acked = pr_acked + 32'(pr_chunk_len);
                            pr_ticks = '0;
                            // a full chunk asks for more, a short one ends the data
                            if (pr_chunk_len == 4'(cfus_pkg::CHUNK_BYTES))
                            begin
                                pr_phase = cfus_pkg::PH_NEED;
                                push_beat(1'b0, '0, '0, '0, cfus_pkg::STAT_NEED);
                            end
                            else
                            begin
                                pr_phase = cfus_pkg::PH_FINAL;
                                push_beat(1'b0, '0, '0, '0, cfus_pkg::STAT_WAITING);
                            end
                        end
                        else
                        begin
                            close_run(1'b1, cfus_pkg::STAT_CRC_FAIL);
                        end
                    end
                    else if (b0 != 8'd0)
                    begin
                        close_run(1'b0, cfus_pkg::STAT_COMPLETE);
                    end
                    else
                    begin
                        close_run(1'b1, cfus_pkg::STAT_FINAL_ERR);
                    end
                end
            end
            cfus_pkg::ACT_TICK:
            begin
                if (pr_phase != cfus_pkg::PH_IDLE && pr_phase != cfus_pkg::PH_NEED)
                begin
                    lim = (pr_phase == cfus_pkg::PH_MODE) ? reg_mode_timeout : reg_timeout;
                    if (pr_ticks != 16'hFFFF)
                    begin
                        pr_ticks++;
                    end
                    if (pr_ticks >= lim)
                    begin
                        // no reset frame on a boot-mode or size-echo timeout
                        if (pr_phase == cfus_pkg::PH_MODE)
                        begin
                            close_run(1'b0, cfus_pkg::STAT_BOOT_FAIL);
                        end
                        else
                        begin
                            close_run(pr_phase != cfus_pkg::PH_SIZE, cfus_pkg::STAT_TIMEOUT);
                        end
                    end
                end
            end
            cfus_pkg::ACT_CHUNK:
            begin
                if (pr_phase == cfus_pkg::PH_NEED)
                begin
                    pr_chunk_len = n;
                    pr_crc       = chunk_crc(rx, n);
                    pr_phase     = cfus_pkg::PH_ACK;
                    pr_ticks     = '0;
                    push_beat(1'b1, id_data, n, rx, cfus_pkg::STAT_WAITING);
                end
            end
            default:
            begin
            end
        endcase
        if (beats_q.size() > queued)
        begin
            beats_q[$].last = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: item beats in bursts of random length with random gaps
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_if.valid <= 1'b0;
        end
        else
        begin
            if (in_if.valid && in_if.ready)
            begin
                predict_upload_step(pending_q.pop_front());
                if (burst_left > 0)
                begin
                    burst_left--;
                end
            end
            // a beat on the bus stays until it is taken
            if (!in_if.valid || in_if.ready)
            begin
                if (burst_left == 0 && gap_left == 0)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        // a long stretch with no gaps at all
                        burst_left = 60;
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 10);
                        gap_left   = $urandom_range(0, 6);
                    end
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_if.valid <= 1'b0;
                end
                else if (pending_q.size() != 0)
                begin
                    in_if.valid    <= 1'b1;
                    in_if.action   <= pending_q[0].action;
                    in_if.frame_id <= pending_q[0].frame_id;
                    in_if.length   <= pending_q[0].length;
                    in_if.payload  <= pending_q[0].payload;
                end
                else
                begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks each result beat and stalls on its own pattern
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cfus_pkg::res_t want;
        if (!rst_n)
        begin
            out_if.ready <= 1'b0;
        end
        else
        begin
            if (out_if.valid && out_if.ready)
            begin
                if (beats_q.size() == 0)
                begin
                    report_mismatch("result beat with nothing expected");
                end
                else
                begin
                    want = beats_q.pop_front();
                    compare_field("tx_valid", 64'(out_if.tx_valid), 64'(want.tx_valid));
                    compare_field("tx_id", 64'(out_if.tx_id), 64'(want.tx_id));
                    compare_field("tx_len", 64'(out_if.tx_len), 64'(want.tx_len));
                    compare_field("tx_data", out_if.tx_data, want.tx_data);
                    compare_field("status", 64'(out_if.status), 64'(want.status));
                    compare_field("bytes_sent", 64'(out_if.bytes_sent),
                                  64'(want.bytes_sent));
                    compare_field("last", 64'(out_if.last), 64'(want.last));
                end
                beat_count++;
            end
            // stall style redrawn periodically: none, coin flip, mask, mostly stalled
            if (stall_cycle % 50 == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_mask = $urandom;
            end
            case (stall_mode)
                0:       out_if.ready <= 1'b1;
                1:       out_if.ready <= 1'($urandom_range(0, 1));
                2:       out_if.ready <= stall_mask[stall_cycle % 32];
                default: out_if.ready <= ($urandom_range(0, 7) == 0);
            endcase
            stall_cycle++;
        end
    end

    // ------------------------------------------------------------------------
    // register writes, only while the block is idle
    // ------------------------------------------------------------------------
    task automatic write_reg(cfus_pkg::cfg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            cfus_pkg::CFG_BASE_ID:      reg_base         = value[10:0];
            cfus_pkg::CFG_BOOT_KEY:     reg_key          = value;
            cfus_pkg::CFG_FW_SIZE:      reg_size         = value;
            cfus_pkg::CFG_TIMEOUT:      reg_timeout      = value[15:0];
            cfus_pkg::CFG_MODE_TIMEOUT: reg_mode_timeout = value[15:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic program_settings(logic [10:0] base, logic [31:0] key, logic [31:0] size,
                                    logic [15:0] tmo, logic [15:0] mode_tmo);
        write_reg(cfus_pkg::CFG_BASE_ID, 32'(base));
        write_reg(cfus_pkg::CFG_BOOT_KEY, key);
        write_reg(cfus_pkg::CFG_FW_SIZE, size);
        write_reg(cfus_pkg::CFG_TIMEOUT, 32'(tmo));
        write_reg(cfus_pkg::CFG_MODE_TIMEOUT, 32'(mode_tmo));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // all items taken, all beats seen, then the drain time
    task automatic wait_drained();
        while (pending_q.size() != 0 || in_if.valid || beats_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // stimulus building blocks
    // ------------------------------------------------------------------------
    task automatic add_item(logic [2:0] act, logic [10:0] id, logic [3:0] len,
                            logic [63:0] pl);
        upload_item_t it;
        it.action   = act;
        it.frame_id = id;
        it.length   = len;
        it.payload  = pl;
        pending_q.push_back(it);
    endtask

    // ticks carry random fields, which the block must not look at
    task automatic add_ticks(int unsigned count);
        repeat (count)
        begin
            add_item(cfus_pkg::ACT_TICK, 11'($urandom), 4'($urandom), rand64());
        end
    endtask

    // a few ticks that stay below the limit
    task automatic idle_ticks(logic [15:0] lim);
        add_ticks($urandom_range(0, (lim > 16'd4) ? 3 : int'(lim) - 1));
    endtask

    function automatic bit wants_expiry(logic [15:0] lim, int unsigned pct);
        return lim <= 16'(EXPIRE_MAX) && $urandom_range(0, 99) < pct;
    endfunction

    // reply frame with a chosen first byte; sometimes over-long
    task automatic add_reply(logic [10:0] id, logic [7:0] b0, int unsigned min_len);
        logic [63:0] pl;
        logic [3:0]  len;
        pl      = rand64();
        pl[7:0] = b0;
        if ($urandom_range(0, 9) == 0)
        begin
            len = 4'($urandom_range(9, 15));
        end
        else
        begin
            len = 4'($urandom_range(min_len, 8));
        end
        add_item(cfus_pkg::ACT_FRAME, id, len, pl);
    endtask

    task automatic gen_noise();
        logic [10:0] id;
        case ($urandom_range(0, 2))
            0:       id = reg_base;
            1:       id = reg_base + cfus_pkg::DATA_OFS;
            default: id = 11'($urandom);
        endcase
        add_item(3'($urandom_range(0, 7)), id, 4'($urandom), rand64());
    endtask

    // mostly well-formed uploads with random content, some broken on purpose
    task automatic gen_upload();
        logic [10:0] id_main;
        logic [10:0] id_data;
        logic [63:0] pl;
        logic [3:0]  len;
        logic [3:0]  n;
        logic [7:0]  crc;
        int          roll;
        int          nfull;
        id_main = reg_base;
        id_data = reg_base + cfus_pkg::DATA_OFS;
        add_item(cfus_pkg::ACT_START, 11'($urandom), 4'($urandom), rand64());
        if ($urandom_range(0, 24) == 0)
        begin
            gen_noise();
        end
        idle_ticks(reg_timeout);

        // key reply
        roll = $urandom_range(0, 99);
        if (roll < 6)
        begin
            add_reply(id_main, 8'd0, 0);
            return;
        end
        if (wants_expiry(reg_timeout, 6))
        begin
            add_ticks(32'(reg_timeout));
            return;
        end
        add_reply(id_main, 8'($urandom_range(1, 255)), 1);
        idle_ticks(reg_timeout);

        // size echo
        roll = $urandom_range(0, 99);
        if (roll < 6)
        begin
            add_item(cfus_pkg::ACT_FRAME, id_main, 4'($urandom), rand64());
            return;
        end
        if (wants_expiry(reg_timeout, 6))
        begin
            add_ticks(32'(reg_timeout));
            return;
        end
        add_item(cfus_pkg::ACT_FRAME, id_main, 4'($urandom_range(4, 15)),
                 {$urandom, reg_size});

        // full chunks, then one short chunk that ends the data
        nfull = $urandom_range(0, 3);
        for (int k = 0; k <= nfull; k++)
        begin
            if (k == nfull)
            begin
                len = 4'($urandom_range(0, 7));
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                len = 4'($urandom_range(9, 15));
            end
            else
            begin
                len = 4'd8;
            end
            case ($urandom_range(0, 9))
                0:       pl = '0;
                1:       pl = '1;
                default: pl = rand64();
            endcase
            n   = (len > 4'd8) ? 4'd8 : len;
            crc = chunk_crc(low_bytes(pl, n), n);
            if ($urandom_range(0, 29) == 0)
            begin
                gen_noise();
            end
            add_item(cfus_pkg::ACT_CHUNK, 11'($urandom), len, pl);
            idle_ticks(reg_timeout);
            roll = $urandom_range(0, 99);
            if (roll < 4)
            begin
                add_reply(id_data, crc ^ 8'($urandom_range(1, 255)), 1);
                return;
            end
            if (wants_expiry(reg_timeout, 4))
            begin
                add_ticks(32'(reg_timeout));
                return;
            end
            add_reply(id_data, crc, 1);
        end

        // final reply
        idle_ticks(reg_timeout);
        roll = $urandom_range(0, 99);
        if (roll < 12)
        begin
            add_reply(id_data, 8'd0, 0);
        end
        else if (wants_expiry(reg_timeout, 5))
        begin
            add_ticks(32'(reg_timeout));
        end
        else
        begin
            add_reply(id_data, 8'($urandom_range(1, 255)), 1);
        end
    endtask

    task automatic gen_boot();
        add_item(cfus_pkg::ACT_BOOT, 11'($urandom), 4'($urandom), rand64());
        idle_ticks(reg_mode_timeout);
        if ($urandom_range(0, 99) < 25)
        begin
            add_reply(reg_base, 8'd0, 0);
        end
        else if (wants_expiry(reg_mode_timeout, 25))
        begin
            add_ticks(32'(reg_mode_timeout));
        end
        else
        begin
            add_reply(reg_base, 8'($urandom_range(1, 255)), 1);
        end
    endtask

    task automatic gen_session();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
        begin
            gen_upload();
        end
        else if (roll < 85)
        begin
            gen_boot();
        end
        else
        begin
            repeat ($urandom_range(1, 3)) gen_noise();
        end
    endtask

    // extremes first, then random settings
    task automatic pick_settings(int idx);
        logic [15:0] tmo;
        case (idx)
            0: program_settings(11'd2027, '1, '1, 16'd1, 16'd1);
            1: program_settings(11'd0, '0, '0, 16'hFFFF, 16'hFFFF);
            2: program_settings(11'd1024, $urandom, 32'($urandom_range(0, 300)),
                                16'd20, 16'd40);
            default:
            begin
                tmo = ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom_range(1, 12));
                program_settings(11'($urandom_range(0, 2027)), $urandom,
                                 $urandom_range(0, 1) ? $urandom : $urandom_range(0, 300),
                                 tmo, 16'($urandom_range(1, EXPIRE_MAX)));
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [10:0] b;
        logic [63:0] ones;
        int          setting_no;
        ones = '1;

        in_if.valid    = 1'b0;
        in_if.action   = cfus_pkg::ACT_TICK;
        in_if.frame_id = '0;
        in_if.length   = '0;
        in_if.payload  = '0;
        out_if.ready   = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = cfus_pkg::CFG_BASE_ID;
        cfg_data       = '0;
        rst_n          = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: short timeouts so expiry takes only a few ticks
        program_settings(11'd2000, $urandom, 32'h0000_1234, 16'd3, 16'd2);
        b = reg_base;
        // short key reply reads as zero: key refused
        add_item(cfus_pkg::ACT_START, '0, '0, '0);
        add_item(cfus_pkg::ACT_FRAME, b, 4'd0, ones);
        // frame on a foreign id is ignored, extra reply bytes are masked
        add_item(cfus_pkg::ACT_START, '1, '1, ones);
        add_item(cfus_pkg::ACT_FRAME, b + 11'd1, 4'd8, 64'd1);
        add_item(cfus_pkg::ACT_FRAME, b, 4'd1, 64'hFFFF_FFFF_FFFF_FF01);
        add_item(cfus_pkg::ACT_FRAME, b, 4'd8, {32'hDEAD_BEEF, reg_size});
        // tick while waiting for a chunk is ignored
        add_ticks(1);
        // over-long chunk taken as eight bytes, then a short chunk
        add_item(cfus_pkg::ACT_CHUNK, '0, 4'd15, ones);
        add_reply(b + cfus_pkg::DATA_OFS, chunk_crc(ones, 4'd8), 1);
        add_item(cfus_pkg::ACT_CHUNK, '0, 4'd3, ones);
        add_reply(b + cfus_pkg::DATA_OFS, chunk_crc(ones, 4'd3), 2);
        add_item(cfus_pkg::ACT_FRAME, b + cfus_pkg::DATA_OFS, 4'd8, 64'h80);
        add_item(ACT_SPARE_TOP, b, 4'd8, ones);
        // boot-mode timeout, then boot mode granted
        add_item(cfus_pkg::ACT_BOOT, '0, '0, '0);
        add_ticks(2);
        add_item(cfus_pkg::ACT_BOOT, '0, '0, '0);
        add_item(cfus_pkg::ACT_FRAME, b, 4'd1, 64'h80);
        // key timeout sends the reset frame, size-echo timeout does not
        add_item(cfus_pkg::ACT_START, '0, '0, '0);
        add_ticks(3);
        add_item(cfus_pkg::ACT_START, '0, '0, '0);
        add_item(cfus_pkg::ACT_FRAME, b, 4'd4, 64'h5A);
        add_ticks(3);
        wait_drained();

        // random part, one batch of sessions per setting
        setting_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            pick_settings(setting_no);
            repeat (SESSIONS_PER_SETTING) gen_session();
            wait_drained();
            setting_no++;
        end

        if (err_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
